// File: design/assert_macros.svh
// Assertion macros shared by the wildcard name matcher modules.
// Depends on nothing; the bodies become empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WNM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define WNM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define WNM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define WNM_ASSERT(label, clk, rst, prop)
`define WNM_ASSERT_IMP(label, clk, rst, ante, cons)
`define WNM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/wnm_pkg.sv
// Types, constants and helpers shared by the wildcard name matcher.
// Depends on nothing.
package wnm_pkg;

   localparam logic [7:0] STAR_CHAR = 8'd42;
   localparam logic [7:0] LF_CHAR   = 8'd10;
   localparam logic [7:0] CR_CHAR   = 8'd13;

   localparam logic ACTION_PATTERN = 1'b0;
   localparam logic ACTION_NAME    = 1'b1;

   localparam int CSR_W     = 3;
   localparam int REQ_DEPTH = 2;
   localparam int RSP_DEPTH = 4;

   typedef struct packed {
      logic       is_name;
      logic [1:0] slot;
      logic [7:0] char_value;
      logic       last;
   } wnm_item_type;

   typedef struct packed {
      logic       matched;
      logic [1:0] match_slot;
   } wnm_result_type;

   function automatic logic is_squeezable(input logic [7:0] c);
      return (c == STAR_CHAR) || (c == LF_CHAR) || (c == CR_CHAR);
   endfunction

endpackage

// File: design/wildcard_name_matcher.sv
// Top level of the wildcard name matcher: front end, engine and result queue.
// Depends on wnm_pkg, wnm_front, wnm_engine, wnm_fifo and assert_macros.svh.
//
// The matcher takes one byte per clock cycle, pattern or name, and keeps doing so
// while results wait in the result queue. Each byte waits in a two-entry request
// queue and is then applied to every pattern position of every slot at once by the
// engine's bit-parallel automata. A name's result is registered in the engine's
// result stage and then written into the result queue, from which it can be read.
// The engine holds back the last byte of a name while the four-entry result queue
// has no free place, and that back-pressure then reaches full.
// Configuration writes are always taken (csr_ready stays high) and must be made while
// no item is in flight.
`include "assert_macros.svh"
module wildcard_name_matcher #(
   parameter int NUM_PATTERNS = 4,
   parameter int PAT_LEN      = 63
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic                         req_action,
   input  logic [1:0]                   req_slot,
   input  logic [7:0]                   req_char_value,
   input  logic                         req_last,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic                         rsp_matched,
   output logic [1:0]                   rsp_match_slot,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [wnm_pkg::CSR_W-1:0]    csr_data
);
   import wnm_pkg::*;

   localparam int RES_W = $bits(wnm_result_type);
   localparam int CNT_W = $clog2(RSP_DEPTH+1);

   logic [CSR_W-1:0] in_use_ff;
   logic             head_valid, head_pop;
   wnm_item_type     head_item;
   logic             res_valid, result_room;
   wnm_result_type   res_data, rsp_head;
   logic [RES_W-1:0] rsp_rd_data;
   logic             out_full;
   logic [CNT_W-1:0] out_count;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= CSR_W'(1);
      end else if (csr_valid && csr_ready) begin
         in_use_ff <= csr_data;
      end
   end

   wnm_front #(
      .NUM_PATTERNS (NUM_PATTERNS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_action     (req_action),
      .req_slot       (req_slot),
      .req_char_value (req_char_value),
      .req_last       (req_last),
      .head_valid     (head_valid),
      .head_item      (head_item),
      .head_pop       (head_pop)
   );

   // Room is counted with the result still in the engine's result stage.
   assign result_room = ({1'b0, out_count} + (CNT_W+1)'(res_valid)) < (CNT_W+1)'(RSP_DEPTH);

   wnm_engine #(
      .NUM_PATTERNS (NUM_PATTERNS),
      .PAT_LEN      (PAT_LEN)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .head_pop        (head_pop),
      .result_room     (result_room),
      .patterns_in_use (in_use_ff),
      .res_valid       (res_valid),
      .res_data        (res_data)
   );

   wnm_fifo #(
      .WIDTH (RES_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (res_valid),
      .wr_data (res_data),
      .pop     (rsp_pop),
      .rd_data (rsp_rd_data),
      .empty   (rsp_empty),
      .full    (out_full),
      .count   (out_count)
   );

   assign rsp_head       = wnm_result_type'(rsp_rd_data);
   assign rsp_matched    = rsp_head.matched;
   assign rsp_match_slot = rsp_head.match_slot;

   `WNM_ASSERT_IMP(a_rsp_no_overrun, clock, reset, res_valid, !out_full)

endmodule

// File: design/wnm_fifo.sv
// Small first-in first-out queue used on both sides of the matcher.
// Depends on nothing; DEPTH must be at least 2.
module wnm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             wr_data,
   input  logic                         pop,
   output logic [WIDTH-1:0]             rd_data,
   output logic                         empty,
   output logic                         full,
   output logic [$clog2(DEPTH+1)-1:0]   count
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign count   = count_ff;
   assign rd_data = store_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: design/wnm_front.sv
// Front end: accepts request items, classifies them and queues them for the engine.
// Depends on wnm_pkg and wnm_fifo.
module wnm_front #(
   parameter int NUM_PATTERNS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_action,
   input  logic [1:0]            req_slot,
   input  logic [7:0]            req_char_value,
   input  logic                  req_last,
   output logic                  head_valid,
   output wnm_pkg::wnm_item_type head_item,
   input  logic                  head_pop
);
   import wnm_pkg::*;

   localparam int ITEM_W = $bits(wnm_item_type);

   wnm_item_type            item;
   logic                    accept;
   logic                    keep;
   logic                    q_empty;
   logic [ITEM_W-1:0]       q_rd_data;
   logic [$clog2(REQ_DEPTH+1)-1:0] q_count;

   always_comb begin
      item.is_name    = (req_action == ACTION_NAME);
      item.slot       = req_slot;
      item.char_value = req_char_value;
      item.last       = req_last;
   end

   // A pattern item for a slot that does not exist is taken and dropped here.
   assign accept = req_push && !req_full;
   assign keep   = item.is_name || (int'(req_slot) < NUM_PATTERNS);

   wnm_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (REQ_DEPTH)
   ) u_req_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (accept && keep),
      .wr_data (item),
      .pop     (head_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty),
      .full    (req_full),
      .count   (q_count)
   );

   assign head_valid = !q_empty && (q_count != '0);
   assign head_item  = wnm_item_type'(q_rd_data);

endmodule

// File: design/wnm_engine.sv
// Back end: pattern slots with their bit-parallel automata and the result stage.
// Depends on wnm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module wnm_engine #(
   parameter int NUM_PATTERNS = 4,
   parameter int PAT_LEN      = 63
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            head_valid,
   input  wnm_pkg::wnm_item_type           head_item,
   output logic                            head_pop,
   input  logic                            result_room,
   input  logic [wnm_pkg::CSR_W-1:0]       patterns_in_use,
   output logic                            res_valid,
   output wnm_pkg::wnm_result_type         res_data
);
   import wnm_pkg::*;

   logic                 name_step, name_end, load_step;
   logic [NUM_PATTERNS-1:0] slot_hit;
   logic [NUM_PATTERNS-1:0] act_idle;

   logic [7:0]           pat_ff     [NUM_PATTERNS][PAT_LEN];
   logic [PAT_LEN-1:0]   star_ff    [NUM_PATTERNS];
   logic [PAT_LEN-1:0]   fill_ff    [NUM_PATTERNS];
   logic [PAT_LEN-1:0]   fill_in    [NUM_PATTERNS];
   logic [PAT_LEN:0]     end_ff     [NUM_PATTERNS];
   logic [PAT_LEN:0]     end_in     [NUM_PATTERNS];
   logic [PAT_LEN:0]     act_ff     [NUM_PATTERNS];
   logic [PAT_LEN:0]     act_in     [NUM_PATTERNS];
   logic [NUM_PATTERNS-1:0] ovf_ff, ovf_in;
   logic [NUM_PATTERNS-1:0] loading_ff, loading_in;
   logic [NUM_PATTERNS-1:0] tail_sq_ff, tail_sq_in;

   logic                    res_valid_ff;
   logic [NUM_PATTERNS-1:0] hit_ff;

   // The last byte of a name needs a place in the result queue before it is taken.
   assign head_pop  = head_valid && (!(head_item.is_name && head_item.last) || result_room);
   assign name_step = head_pop && head_item.is_name;
   assign name_end  = name_step && head_item.last;
   assign load_step = head_pop && !head_item.is_name;

   for (genvar s = 0; s < NUM_PATTERNS; s++) begin : g_slot
      logic               sel, keep, store_ok, in_use;
      logic [PAT_LEN:0]   end_base;
      logic [PAT_LEN-1:0] fill_base;
      logic               tail_base, ovf_base;
      logic [PAT_LEN-1:0] star_eff, eq_vec, wr_vec;
      logic [PAT_LEN:0]   act_closed, nxt, nxt_closed;

      assign sel    = load_step && (int'(head_item.slot) == s);
      assign in_use = (int'(patterns_in_use) > s);

      always_comb begin
         for (int i = 0; i < PAT_LEN; i++) begin
            eq_vec[i] = fill_ff[s][i] && (pat_ff[s][i] == head_item.char_value);
         end
      end

      // Stars are never stored back to back, so one closure step is enough.
      assign star_eff   = star_ff[s] & fill_ff[s];
      assign act_closed = act_ff[s] | {star_eff & act_ff[s][PAT_LEN-1:0], 1'b0};
      assign nxt        = {act_closed[PAT_LEN-1:0] & eq_vec, 1'b0}
                        | {1'b0, act_closed[PAT_LEN-1:0] & star_eff};
      assign nxt_closed = nxt | {star_eff & nxt[PAT_LEN-1:0], 1'b0};
      assign slot_hit[s] = (|(nxt_closed & end_ff[s])) && !ovf_ff[s] && in_use;
      assign act_idle[s] = (act_ff[s] == (PAT_LEN+1)'(1));

      always_comb begin
         end_base  = loading_ff[s] ? end_ff[s] : (PAT_LEN+1)'(1);
         fill_base = loading_ff[s] ? fill_ff[s] : '0;
         tail_base = loading_ff[s] && tail_sq_ff[s];
         ovf_base  = loading_ff[s] && ovf_ff[s];
         keep      = !(is_squeezable(head_item.char_value) && tail_base);
         store_ok  = sel && keep && !end_base[PAT_LEN];
         wr_vec    = store_ok ? end_base[PAT_LEN-1:0] : '0;

         end_in[s]     = end_ff[s];
         fill_in[s]    = fill_ff[s];
         tail_sq_in[s] = tail_sq_ff[s];
         ovf_in[s]     = ovf_ff[s];
         loading_in[s] = loading_ff[s];
         act_in[s]     = act_ff[s];

         if (sel) begin
            end_in[s]     = end_base;
            fill_in[s]    = fill_base;
            tail_sq_in[s] = tail_base;
            ovf_in[s]     = ovf_base;
            loading_in[s] = !head_item.last;
            if (!loading_ff[s]) begin
               act_in[s] = (PAT_LEN+1)'(1);
            end
            if (keep) begin
               if (end_base[PAT_LEN]) begin
                  ovf_in[s] = 1'b1;
               end else begin
                  fill_in[s]    = fill_base | end_base[PAT_LEN-1:0];
                  end_in[s]     = {end_base[PAT_LEN-1:0], 1'b0};
                  tail_sq_in[s] = is_squeezable(head_item.char_value);
               end
            end
         end
         if (name_step) begin
            act_in[s] = head_item.last ? (PAT_LEN+1)'(1) : nxt;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            end_ff[s]     <= (PAT_LEN+1)'(1);
            fill_ff[s]    <= '0;
            tail_sq_ff[s] <= 1'b0;
            ovf_ff[s]     <= 1'b0;
            loading_ff[s] <= 1'b0;
            act_ff[s]     <= (PAT_LEN+1)'(1);
         end else begin
            end_ff[s]     <= end_in[s];
            fill_ff[s]    <= fill_in[s];
            tail_sq_ff[s] <= tail_sq_in[s];
            ovf_ff[s]     <= ovf_in[s];
            loading_ff[s] <= loading_in[s];
            act_ff[s]     <= act_in[s];
         end
      end

      always_ff @(posedge clock) begin
         for (int i = 0; i < PAT_LEN; i++) begin
            if (wr_vec[i]) begin
               pat_ff[s][i]  <= head_item.char_value;
               star_ff[s][i] <= (head_item.char_value == STAR_CHAR);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= name_end;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= slot_hit;
   end

   // The lowest matching slot wins.
   always_comb begin
      res_data.matched    = |hit_ff;
      res_data.match_slot = '0;
      for (int s = NUM_PATTERNS-1; s >= 0; s--) begin
         if (hit_ff[s]) begin
            res_data.match_slot = 2'(s);
         end
      end
   end

   assign res_valid = res_valid_ff;

   `WNM_ASSERT_NXT(a_act_cleared, clock, reset, name_end, act_idle == '1)
   for (genvar s = 0; s < NUM_PATTERNS; s++) begin : g_chk
      `WNM_ASSERT(a_end_onehot, clock, reset, $onehot(end_ff[s]))
      `WNM_ASSERT_IMP(a_ovf_full, clock, reset, ovf_ff[s], end_ff[s][PAT_LEN])
   end

endmodule
